// ===== src/tcw_pkg.sv =====
// ============================================================================
// Text console writer package
// Request codes, cell constants, sequencer states and shared types.
// ============================================================================
package tcw_pkg;

    // Request kinds carried on the input stream's tuser.
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // A blank cell is a space with the default attribute.
    localparam logic [15:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]  ATTR_RESET   = 8'h0F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCROLL,
        ST_DRAIN,
        ST_RESP
    } state_t;

    // What a put does besides moving the cursor.
    typedef struct packed {
        logic write_cell;
        logic scroll;
    } cur_flags_t;

endpackage

// ===== src/tcw_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered, write-first.
// ============================================================================
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wa,
    input  logic [WIDTH-1:0]         wd,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] ra,
    output logic [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            // A read of the cell being written returns the new value.
            if (we && (wa == ra))
            begin
                rd_reg <= wd;
            end
            else
            begin
                rd_reg <= mem[ra];
            end
        end
    end

    assign rd = rd_reg;

endmodule

// ===== src/tcw_cursor.sv =====
// ============================================================================
// Cursor advance unit
// Computes the cursor position after one put and whether the screen scrolls.
// ============================================================================
module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic [$clog2(COLUMNS)-1:0] col_in,
    input  logic [$clog2(ROWS)-1:0]    row_in,
    input  logic [7:0]                 code,
    output logic [$clog2(COLUMNS)-1:0] col_out,
    output logic [$clog2(ROWS)-1:0]    row_out,
    output tcw_pkg::cur_flags_t        flags
);

    import tcw_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    logic [CW:0] c_inc;
    logic [RW:0] r_inc;
    logic        is_nl;
    logic        wrap;
    logic        row_adv;
    logic        bottom;

    always_comb
    begin
        is_nl   = (code == NEWLINE_CODE);
        c_inc   = {1'b0, col_in} + {{CW{1'b0}}, 1'b1};
        r_inc   = {1'b0, row_in} + {{RW{1'b0}}, 1'b1};
        wrap    = !is_nl && (c_inc == (CW+1)'(COLUMNS));
        row_adv = is_nl || wrap;
        // Falling off the bottom keeps the cursor on the last row.
        bottom  = row_adv && (r_inc == (RW+1)'(ROWS));

        col_out = row_adv ? '0 : c_inc[CW-1:0];
        if (row_adv && !bottom)
        begin
            row_out = r_inc[RW-1:0];
        end
        else
        begin
            row_out = row_in;
        end

        flags.write_cell = !is_nl;
        flags.scroll     = bottom;
    end

endmodule

// ===== src/text_console_writer.sv =====
// ============================================================================
// Text console writer
// Character-cell screen with a write cursor, scrolling, clear and cell reads.
// ============================================================================
// Sequence: a put without scroll, a read or an unused request goes straight
// to the response state; a scroll or a clear first sweeps every cell through
// the single write port of the cell RAM, drains the last write, then responds.
// Throughput: one request at a time; the next is taken once the result is
// loaded into the output register, which waits while the consumer stalls.
// Reset: cursor homes, attribute becomes 0x0F, and a clearing pass writes
// blanks to every cell before requests are taken.
// ============================================================================
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,

    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: char_code [7:0], cell_row [12:8], cell_col [19:13], zero fill.
    input  logic [23:0] s_axis_tdata,
    // tuser: req_type [1:0].
    input  logic [1:0]  s_axis_tuser,

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: cell_data [15:0], cursor_col [22:16], cursor_row [27:23],
    // scrolled [28], zero fill.
    output logic [31:0] m_axis_tdata,

    // Attribute register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    // Request fields.
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
    logic [1:0] req_type;

    assign char_code = s_axis_tdata[7:0];
    assign cell_row  = s_axis_tdata[12:8];
    assign cell_col  = s_axis_tdata[19:13];
    assign req_type  = s_axis_tuser;

    // Sequencer and sweep state.
    state_t          state_reg, state_next;
    logic [AW-1:0]   a_reg, a_next;
    logic            reply_reg, reply_next;

    // Pending RAM write, registered ahead of the write itself so that
    // a scroll can move one cell per cycle through the registered read.
    logic            pend_reg, pend_next;
    logic [AW-1:0]   dst_reg, dst_next;
    logic [15:0]     wdat_reg, wdat_next;
    logic            fromram_reg, fromram_next;

    // Result bookkeeping.
    logic            rdhit_reg, rdhit_next;
    logic            scr_reg, scr_next;

    // Cursor and attribute.
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [7:0]      attr_reg;

    // Output register.
    logic            out_valid_reg, out_valid_next;
    logic [31:0]     out_data_reg, out_data_next;

    // RAM ports.
    logic            ram_re;
    logic [AW-1:0]   ram_ra;
    logic [15:0]     ram_wd;
    logic [15:0]     ram_rd;

    // Cursor unit outputs.
    logic [CW-1:0]   cur_col;
    logic [RW-1:0]   cur_row;
    cur_flags_t      cur_flags;

    // Shared linear address: the read cell for reads, the cursor otherwise.
    logic            sel_cell;
    logic [31:0]     lin_w;
    logic [AW-1:0]   lin_addr;
    logic            in_range;
    logic [AW:0]     src_w;
    logic            blank_zone;
    logic [31:0]     col32;
    logic [31:0]     row32;
    logic [15:0]     res_data;

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_cursor (
        .col_in  (col_reg),
        .row_in  (row_reg),
        .code    (char_code),
        .col_out (cur_col),
        .row_out (cur_row),
        .flags   (cur_flags)
    );

    assign ram_wd = fromram_reg ? ram_rd : wdat_reg;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk (clk),
        .we  (pend_reg),
        .wa  (dst_reg),
        .wd  (ram_wd),
        .re  (ram_re),
        .ra  (ram_ra),
        .rd  (ram_rd)
    );

    assign sel_cell = (req_type == REQ_READ);
    assign lin_w    = (sel_cell ? 32'(cell_row) : 32'(row_reg)) * 32'(COLUMNS)
                    + (sel_cell ? 32'(cell_col) : 32'(col_reg));
    assign lin_addr = lin_w[AW-1:0];
    assign in_range = (32'(cell_row) < 32'(ROWS)) && (32'(cell_col) < 32'(COLUMNS));

    // During a scroll, destination a takes the cell one row below it; the
    // last row is filled with blanks instead.
    assign src_w      = {1'b0, a_reg} + (AW+1)'(COLUMNS);
    assign blank_zone = (a_reg >= AW'(CELLS - COLUMNS));

    assign col32    = 32'(col_reg);
    assign row32    = 32'(row_reg);
    assign res_data = rdhit_reg ? ram_rd : 16'h0000;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            a_reg         <= '0;
            reply_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            rdhit_reg     <= 1'b0;
            scr_reg       <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            reply_reg     <= reply_next;
            pend_reg      <= pend_next;
            rdhit_reg     <= rdhit_next;
            scr_reg       <= scr_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        dst_reg      <= dst_next;
        wdat_reg     <= wdat_next;
        fromram_reg  <= fromram_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        reply_next     = reply_reg;
        pend_next      = 1'b0;
        dst_next       = dst_reg;
        wdat_next      = wdat_reg;
        fromram_next   = 1'b0;
        rdhit_next     = rdhit_reg;
        scr_next       = scr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        ram_re         = 1'b0;
        ram_ra         = lin_addr;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // The result leaves when the consumer takes it.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    scr_next   = 1'b0;
                    rdhit_next = 1'b0;
                    reply_next = 1'b1;
                    a_next     = '0;
                    state_next = ST_RESP;
                    case (req_type)
                        REQ_PUT:
                        begin
                            col_next = cur_col;
                            row_next = cur_row;
                            scr_next = cur_flags.scroll;
                            if (cur_flags.write_cell)
                            begin
                                pend_next = 1'b1;
                                dst_next  = lin_addr;
                                wdat_next = {attr_reg, char_code};
                            end
                            if (cur_flags.scroll)
                            begin
                                state_next = ST_SCROLL;
                            end
                        end
                        REQ_READ:
                        begin
                            ram_re     = 1'b1;
                            rdhit_next = in_range;
                        end
                        REQ_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            // Unused request: answer with the cursor alone.
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                pend_next = 1'b1;
                dst_next  = a_reg;
                wdat_next = BLANK_CELL;
                if (a_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    a_next = a_reg + 1'b1;
                end
            end

            ST_SCROLL:
            begin
                pend_next    = 1'b1;
                dst_next     = a_reg;
                wdat_next    = BLANK_CELL;
                fromram_next = !blank_zone;
                ram_re       = !blank_zone;
                ram_ra       = src_w[AW-1:0];
                if (a_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    a_next = a_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                // The last pending write lands in this cycle.
                state_next = reply_reg ? ST_RESP : ST_IDLE;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, scr_reg, row32[4:0], col32[6:0], res_data};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
